@@ rtl/stride_dilation_scatter_index_defines.svh @@
// Assertion helpers for the scatter index block.
`ifndef STRIDE_DILATION_SCATTER_INDEX_DEFINES_SVH
`define STRIDE_DILATION_SCATTER_INDEX_DEFINES_SVH

`ifndef SYNTHESIS
`define SDSI_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sdsi assertion failed");
`define SDSI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sdsi assertion failed");
`else
`define SDSI_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define SDSI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/sdsi_pkg.sv @@
package sdsi_pkg;

	localparam int MAX_DIM    = 1024;
	localparam int MAX_STRIDE = 16;
	localparam int CNT_W      = $clog2(MAX_DIM);
	localparam int DIM_W      = CNT_W + 1;
	localparam int STRIDE_W   = $clog2(MAX_STRIDE) + 1;
	localparam int GRID_W     = 15;
	localparam int DATA_W     = 32;
	localparam int IDX_W      = 38;
	localparam int SPAN_W     = CNT_W + STRIDE_W;
	localparam int POS_W      = GRID_W + 3;
	localparam int CELL_W     = 2 * GRID_W;
	localparam int REG_SEL_W  = 3;

	localparam logic [REG_SEL_W-1:0] REG_IN_HEIGHT   = 3'd0;
	localparam logic [REG_SEL_W-1:0] REG_IN_WIDTH    = 3'd1;
	localparam logic [REG_SEL_W-1:0] REG_IN_CHANNELS = 3'd2;
	localparam logic [REG_SEL_W-1:0] REG_STRIDE_ROWS = 3'd3;
	localparam logic [REG_SEL_W-1:0] REG_STRIDE_COLS = 3'd4;
	localparam logic [REG_SEL_W-1:0] REG_GRID_HEIGHT = 3'd5;
	localparam logic [REG_SEL_W-1:0] REG_GRID_WIDTH  = 3'd6;

	localparam int MID_DEPTH = 4;
	localparam int MID_PTR_W = $clog2(MID_DEPTH);
	localparam int OUT_DEPTH = 8;
	localparam int OUT_PTR_W = $clog2(OUT_DEPTH);

	// effective (clamped) configuration
	typedef struct packed {
		logic [DIM_W-1:0]    height;
		logic [DIM_W-1:0]    width;
		logic [DIM_W-1:0]    channels;
		logic [STRIDE_W-1:0] stride_r;
		logic [STRIDE_W-1:0] stride_c;
		logic [GRID_W-1:0]   grid_h;
		logic [GRID_W-1:0]   grid_w;
	} cfg_t;

	typedef struct packed {
		logic [CNT_W-1:0]  row;
		logic [CNT_W-1:0]  col;
		logic [CNT_W-1:0]  chan;
		logic [DATA_W-1:0] value;
		logic              last;
	} item_t;

	typedef struct packed {
		logic [IDX_W-1:0]  grid_index;
		logic [DATA_W-1:0] data;
		logic              in_grid;
		logic              last;
		logic              err;
	} result_t;

	function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v == '0)
			r = DIM_W'(1);
		else if (v > DIM_W'(MAX_DIM))
			r = DIM_W'(MAX_DIM);
		else
			r = v;
		return r;
	endfunction

	function automatic logic [STRIDE_W-1:0] eff_stride(input logic [STRIDE_W-1:0] v);
		logic [STRIDE_W-1:0] r;
		r = (v > STRIDE_W'(MAX_STRIDE)) ? STRIDE_W'(MAX_STRIDE) : v;
		return r;
	endfunction

endpackage

@@ rtl/sdsi_front.sv @@
`include "stride_dilation_scatter_index_defines.svh"

module sdsi_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  sdsi_pkg::cfg_t              cfg,
	input  logic                        restart,
	input  logic                        push,
	output logic                        full,
	input  logic [sdsi_pkg::DATA_W-1:0] value,
	input  logic                        q_pop,
	output logic                        q_empty,
	output sdsi_pkg::item_t             q_item
);

	logic [sdsi_pkg::CNT_W-1:0] row_q, col_q, chan_q;
	logic [sdsi_pkg::CNT_W-1:0] row_max, col_max, chan_max;
	logic                       row_last, col_last, chan_last, accept;
	sdsi_pkg::item_t            new_item;

	sdsi_pkg::item_t              mem_q [sdsi_pkg::MID_DEPTH];
	logic [sdsi_pkg::MID_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [sdsi_pkg::MID_PTR_W:0]   cnt_q;

	assign row_max   = sdsi_pkg::CNT_W'(cfg.height - 1'b1);
	assign col_max   = sdsi_pkg::CNT_W'(cfg.width - 1'b1);
	assign chan_max  = sdsi_pkg::CNT_W'(cfg.channels - 1'b1);
	assign row_last  = (row_q == row_max);
	assign col_last  = (col_q == col_max);
	assign chan_last = (chan_q == chan_max);

	assign full   = (cnt_q == (sdsi_pkg::MID_PTR_W+1)'(sdsi_pkg::MID_DEPTH));
	assign accept = push && !full;

	always_comb begin
		new_item.row   = row_q;
		new_item.col   = col_q;
		new_item.chan  = chan_q;
		new_item.value = value;
		new_item.last  = row_last && col_last && chan_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			col_q  <= '0;
			chan_q <= '0;
		end else if (restart) begin
			row_q  <= '0;
			col_q  <= '0;
			chan_q <= '0;
		end else if (accept) begin
			if (!chan_last) begin
				chan_q <= chan_q + 1'b1;
			end else begin
				chan_q <= '0;
				if (!col_last) begin
					col_q <= col_q + 1'b1;
				end else begin
					col_q <= '0;
					row_q <= row_last ? '0 : row_q + 1'b1;
				end
			end
		end
	end

	// transaction queue toward the back end
	assign q_empty = (cnt_q == '0);
	assign q_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (accept)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (q_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (accept && !q_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (!accept && q_pop)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			mem_q[wr_ptr_q] <= new_item;
	end

	`SDSI_ASSERT_NOW(a_mid_cnt_bound, clk, arst_n, 1'b1,
		cnt_q <= (sdsi_pkg::MID_PTR_W+1)'(sdsi_pkg::MID_DEPTH))
	`SDSI_ASSERT_NOW(a_cnt_in_range, clk, arst_n, 1'b1,
		(row_q <= row_max) && (col_q <= col_max) && (chan_q <= chan_max))
	`SDSI_ASSERT_NEXT(a_frame_wrap, clk, arst_n, accept && new_item.last,
		(row_q == '0) && (col_q == '0) && (chan_q == '0))

endmodule

@@ rtl/sdsi_back.sv @@
`include "stride_dilation_scatter_index_defines.svh"

module sdsi_back (
	input  logic              clk,
	input  logic              arst_n,
	input  sdsi_pkg::cfg_t    cfg,
	input  logic              q_empty,
	input  sdsi_pkg::item_t   q_item,
	output logic              q_pop,
	input  logic              pop,
	output logic              empty,
	output sdsi_pkg::result_t res
);

	localparam int CNT_W = sdsi_pkg::OUT_PTR_W + 1;

	// stage 1: offsets and spans
	logic                          v_s1;
	logic [sdsi_pkg::SPAN_W-1:0]   row_off_s1, col_off_s1, span_r_s1, span_c_s1;
	logic [sdsi_pkg::CNT_W-1:0]    chan_s1;
	logic [sdsi_pkg::DATA_W-1:0]   value_s1;
	logic                          last_s1;
	// stage 2: signed grid positions
	logic                          v_s2;
	logic signed [sdsi_pkg::POS_W-1:0] pos_r_s2, pos_c_s2;
	logic [sdsi_pkg::CNT_W-1:0]    chan_s2;
	logic [sdsi_pkg::DATA_W-1:0]   value_s2;
	logic                          last_s2;
	// stage 3: cell number and inside test
	logic                          v_s3;
	logic [sdsi_pkg::CELL_W-1:0]   cell_s3;
	logic                          ok_s3;
	logic                          err_s3;
	logic [sdsi_pkg::CNT_W-1:0]    chan_s3;
	logic [sdsi_pkg::DATA_W-1:0]   value_s3;
	logic                          last_s3;

	logic [sdsi_pkg::SPAN_W-1:0]       row_off, col_off, span_r, span_c;
	logic signed [sdsi_pkg::POS_W-1:0] diff_r, diff_c, half_r, half_c, pos_r, pos_c;
	logic                              in_r, in_c, err;
	logic [sdsi_pkg::CELL_W-1:0]       cell_num;
	logic [sdsi_pkg::IDX_W-1:0]        idx;
	sdsi_pkg::result_t                 new_res;

	sdsi_pkg::result_t              mem_q [sdsi_pkg::OUT_DEPTH];
	logic [sdsi_pkg::OUT_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]               cnt_q;
	logic [CNT_W-1:0]               inflight, committed;
	logic                           out_pop;

	// launch only when every transaction in flight has a slot waiting
	assign inflight  = CNT_W'(v_s1) + CNT_W'(v_s2) + CNT_W'(v_s3);
	assign committed = cnt_q + inflight;
	assign q_pop     = !q_empty && (committed < CNT_W'(sdsi_pkg::OUT_DEPTH));

	always_comb begin
		row_off = sdsi_pkg::SPAN_W'(q_item.row) * sdsi_pkg::SPAN_W'(cfg.stride_r);
		col_off = sdsi_pkg::SPAN_W'(q_item.col) * sdsi_pkg::SPAN_W'(cfg.stride_c);
		span_r  = sdsi_pkg::SPAN_W'(sdsi_pkg::CNT_W'(cfg.height - 1'b1))
			* sdsi_pkg::SPAN_W'(cfg.stride_r);
		span_c  = sdsi_pkg::SPAN_W'(sdsi_pkg::CNT_W'(cfg.width - 1'b1))
			* sdsi_pkg::SPAN_W'(cfg.stride_c);
	end

	// half padding, truncated toward zero
	always_comb begin
		diff_r = $signed({3'b000, cfg.grid_h}) - $signed({3'b000, span_r_s1})
			- sdsi_pkg::POS_W'(1);
		diff_c = $signed({3'b000, cfg.grid_w}) - $signed({3'b000, span_c_s1})
			- sdsi_pkg::POS_W'(1);
		half_r = (diff_r + $signed(sdsi_pkg::POS_W'(diff_r[sdsi_pkg::POS_W-1]))) >>> 1;
		half_c = (diff_c + $signed(sdsi_pkg::POS_W'(diff_c[sdsi_pkg::POS_W-1]))) >>> 1;
		pos_r  = half_r + $signed({3'b000, row_off_s1});
		pos_c  = half_c + $signed({3'b000, col_off_s1});
	end

	always_comb begin
		err  = (cfg.stride_r == '0) || (cfg.stride_c == '0);
		in_r = !pos_r_s2[sdsi_pkg::POS_W-1] && (pos_r_s2 < $signed({3'b000, cfg.grid_h}));
		in_c = !pos_c_s2[sdsi_pkg::POS_W-1] && (pos_c_s2 < $signed({3'b000, cfg.grid_w}));
		cell_num = sdsi_pkg::CELL_W'(pos_r_s2[sdsi_pkg::GRID_W-1:0])
			* sdsi_pkg::CELL_W'(cfg.grid_w)
			+ sdsi_pkg::CELL_W'(pos_c_s2[sdsi_pkg::GRID_W-1:0]);
	end

	always_comb begin
		idx = sdsi_pkg::IDX_W'(cell_s3) * sdsi_pkg::IDX_W'(cfg.channels)
			+ sdsi_pkg::IDX_W'(chan_s3);
		new_res.grid_index = ok_s3 ? idx : '0;
		new_res.data       = value_s3;
		new_res.in_grid    = ok_s3;
		new_res.last       = last_s3;
		new_res.err        = err_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= q_pop;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		row_off_s1 <= row_off;
		col_off_s1 <= col_off;
		span_r_s1  <= span_r;
		span_c_s1  <= span_c;
		chan_s1    <= q_item.chan;
		value_s1   <= q_item.value;
		last_s1    <= q_item.last;

		pos_r_s2   <= pos_r;
		pos_c_s2   <= pos_c;
		chan_s2    <= chan_s1;
		value_s2   <= value_s1;
		last_s2    <= last_s1;

		cell_s3    <= cell_num;
		ok_s3      <= in_r && in_c && !err;
		err_s3     <= err;
		chan_s3    <= chan_s2;
		value_s3   <= value_s2;
		last_s3    <= last_s2;
	end

	// result queue
	assign empty   = (cnt_q == '0);
	assign out_pop = pop && !empty;
	assign res     = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (v_s3)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (out_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (v_s3 && !out_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (!v_s3 && out_pop)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s3)
			mem_q[wr_ptr_q] <= new_res;
	end

	`SDSI_ASSERT_NOW(a_credit_bound, clk, arst_n, 1'b1,
		committed <= CNT_W'(sdsi_pkg::OUT_DEPTH))
	`SDSI_ASSERT_NEXT(a_launch_to_s1, clk, arst_n, q_pop, v_s1)
	`SDSI_ASSERT_NOW(a_err_no_write, clk, arst_n, v_s3 && err_s3,
		!ok_s3 && (new_res.grid_index == '0))

endmodule

@@ rtl/stride_dilation_scatter_index.sv @@
// Scatter index generator for zero-insertion upsampling. Feature map elements are pushed in
// row, column, channel order; each one yields a result with its flat index in the dilated
// output grid, the element itself, an inside flag (0 when the position is cropped), a
// frame-last flag and a config error flag (either stride zero, nothing written). One element
// per cycle is sustained while results are popped in time; each passes the input queue,
// three address arithmetic stages (grid row times grid width, then cell times channel
// count) and the result queue. Any write to a listed register restarts the frame; the user
// sees that registers are written only while no transaction is in flight (not enforced).
`include "stride_dilation_scatter_index_defines.svh"

module stride_dilation_scatter_index (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [sdsi_pkg::REG_SEL_W-1:0]       cfg_index,
	input  logic [sdsi_pkg::GRID_W-1:0]          cfg_wdata,
	input  logic                                 push,
	output logic                                 full,
	input  logic [sdsi_pkg::DATA_W-1:0]          value,
	input  logic                                 pop,
	output logic                                 empty,
	output logic [sdsi_pkg::IDX_W-1:0]           grid_index,
	output logic [sdsi_pkg::DATA_W-1:0]          data,
	output logic                                 inside_res,
	output logic                                 frame_last,
	output logic                                 config_error
);

	logic [sdsi_pkg::DIM_W-1:0]    in_height_q, in_width_q, in_channels_q;
	logic [sdsi_pkg::STRIDE_W-1:0] stride_rows_q, stride_cols_q;
	logic [sdsi_pkg::GRID_W-1:0]   grid_height_q, grid_width_q;
	logic                          restart;
	sdsi_pkg::cfg_t                cfg;
	logic                          q_pop, q_empty;
	sdsi_pkg::item_t               q_item;
	sdsi_pkg::result_t             res;

	always_comb begin
		case (cfg_index)
			sdsi_pkg::REG_IN_HEIGHT, sdsi_pkg::REG_IN_WIDTH, sdsi_pkg::REG_IN_CHANNELS,
			sdsi_pkg::REG_STRIDE_ROWS, sdsi_pkg::REG_STRIDE_COLS,
			sdsi_pkg::REG_GRID_HEIGHT, sdsi_pkg::REG_GRID_WIDTH: restart = cfg_we;
			default: restart = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_height_q   <= sdsi_pkg::DIM_W'(1);
			in_width_q    <= sdsi_pkg::DIM_W'(1);
			in_channels_q <= sdsi_pkg::DIM_W'(1);
			stride_rows_q <= sdsi_pkg::STRIDE_W'(1);
			stride_cols_q <= sdsi_pkg::STRIDE_W'(1);
			grid_height_q <= sdsi_pkg::GRID_W'(1);
			grid_width_q  <= sdsi_pkg::GRID_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				sdsi_pkg::REG_IN_HEIGHT:   in_height_q   <= cfg_wdata[sdsi_pkg::DIM_W-1:0];
				sdsi_pkg::REG_IN_WIDTH:    in_width_q    <= cfg_wdata[sdsi_pkg::DIM_W-1:0];
				sdsi_pkg::REG_IN_CHANNELS: in_channels_q <= cfg_wdata[sdsi_pkg::DIM_W-1:0];
				sdsi_pkg::REG_STRIDE_ROWS: stride_rows_q <= cfg_wdata[sdsi_pkg::STRIDE_W-1:0];
				sdsi_pkg::REG_STRIDE_COLS: stride_cols_q <= cfg_wdata[sdsi_pkg::STRIDE_W-1:0];
				sdsi_pkg::REG_GRID_HEIGHT: grid_height_q <= cfg_wdata;
				sdsi_pkg::REG_GRID_WIDTH:  grid_width_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.height   = sdsi_pkg::eff_dim(in_height_q);
		cfg.width    = sdsi_pkg::eff_dim(in_width_q);
		cfg.channels = sdsi_pkg::eff_dim(in_channels_q);
		cfg.stride_r = sdsi_pkg::eff_stride(stride_rows_q);
		cfg.stride_c = sdsi_pkg::eff_stride(stride_cols_q);
		cfg.grid_h   = grid_height_q;
		cfg.grid_w   = grid_width_q;
	end

	sdsi_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.restart (restart),
		.push    (push),
		.full    (full),
		.value   (value),
		.q_pop   (q_pop),
		.q_empty (q_empty),
		.q_item  (q_item)
	);

	sdsi_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.q_empty (q_empty),
		.q_item  (q_item),
		.q_pop   (q_pop),
		.pop     (pop),
		.empty   (empty),
		.res     (res)
	);

	assign grid_index   = res.grid_index;
	assign data         = res.data;
	assign inside_res   = res.in_grid;
	assign frame_last   = res.last;
	assign config_error = res.err;

	`SDSI_ASSERT_NOW(a_dims_clamped, clk, arst_n, 1'b1,
		(cfg.height != '0) && (cfg.width != '0) && (cfg.channels != '0))
	`SDSI_ASSERT_NOW(a_strides_clamped, clk, arst_n, 1'b1,
		(cfg.stride_r <= sdsi_pkg::STRIDE_W'(sdsi_pkg::MAX_STRIDE))
		&& (cfg.stride_c <= sdsi_pkg::STRIDE_W'(sdsi_pkg::MAX_STRIDE)))
	`SDSI_ASSERT_NOW(a_err_not_inside, clk, arst_n, !empty && config_error, !inside_res)

endmodule
